// ===== src/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, types and helpers for the masked byte pattern search.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int MAX_REGION  = 1048576;

	localparam int BYTE_W     = 8;
	localparam int WORD_W     = MAX_PATTERN * BYTE_W;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_LEN_W  = 4;
	localparam int OFFSET_W   = 20;

	localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
	localparam int HIST_IW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int WIN_D     = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam int INDEX_W   = $clog2(MAX_REGION + 1);
	localparam int SUM_W     = ((INDEX_W > OFFSET_W) ? INDEX_W : OFFSET_W) + 1;

	// output tdata: found, match_offset, region_overflow, padded to bytes
	localparam int RES_W    = 1 + OFFSET_W + 1;
	localparam int RES_DW   = ((RES_W + 7) / 8) * 8;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MATCH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MASK   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE    = CFG_IDX_W'(3);

	localparam logic MODE_FIRST = 1'b0;
	localparam logic MODE_LAST  = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0]    pattern_match;
		logic [WORD_W-1:0]    pattern_mask;
		logic [CFG_LEN_W-1:0] pattern_length;
		logic                 search_mode;
	} cfg_t;

	typedef logic [WIN_D-1:0][BYTE_W-1:0] window_t;

	// clamp the programmed length to 1..MAX_PATTERN
	function automatic logic [LEN_W-1:0] active_len(input logic [CFG_LEN_W-1:0] raw);
		logic [LEN_W-1:0] n;
		if (raw == '0) begin
			n = LEN_W'(1);
		end else if (32'(raw) > MAX_PATTERN) begin
			n = LEN_W'(MAX_PATTERN);
		end else begin
			n = LEN_W'(raw);
		end
		return n;
	endfunction

endpackage

// ===== src/mbps_cfg.sv =====
// ----------------------------------------------------------------------------
// mbps_cfg
// Pattern and mode registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module mbps_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0] wr_data,
	output mbps_pkg::cfg_t                 cfg
);

	mbps_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_match  <= '0;
			cfg_q.pattern_mask   <= '1;
			cfg_q.pattern_length <= mbps_pkg::CFG_LEN_W'(1);
			cfg_q.search_mode    <= mbps_pkg::MODE_FIRST;
		end else if (wr_en) begin
			case (wr_index)
				mbps_pkg::CFG_PATTERN_MATCH: begin
					cfg_q.pattern_match <= wr_data[mbps_pkg::WORD_W-1:0];
				end
				mbps_pkg::CFG_PATTERN_MASK: begin
					cfg_q.pattern_mask <= wr_data[mbps_pkg::WORD_W-1:0];
				end
				mbps_pkg::CFG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= wr_data[mbps_pkg::CFG_LEN_W-1:0];
				end
				mbps_pkg::CFG_SEARCH_MODE: begin
					cfg_q.search_mode <= wr_data[0];
				end
				default: begin
					// drop writes to unknown registers
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/mbps_match.sv =====
// ----------------------------------------------------------------------------
// mbps_match
// Parallel masked compare of the newest byte and the byte window against
// every active pattern position.
// ----------------------------------------------------------------------------
module mbps_match (
	input  logic [mbps_pkg::WORD_W-1:0] pattern_match,
	input  logic [mbps_pkg::WORD_W-1:0] pattern_mask,
	input  logic [mbps_pkg::LEN_W-1:0]  len,
	input  logic [mbps_pkg::BYTE_W-1:0] cur_byte,
	input  mbps_pkg::window_t           window,
	output logic                        hit
);

	logic [mbps_pkg::MAX_PATTERN-1:0][mbps_pkg::BYTE_W-1:0] hist;

	// newest byte first, then the window from most recent back
	always_comb begin
		hist[0] = cur_byte;
		for (int i = 1; i < mbps_pkg::MAX_PATTERN; i++) begin
			hist[i] = window[i-1];
		end
	end

	always_comb begin
		logic [mbps_pkg::LEN_W-1:0]  lag;
		logic [mbps_pkg::BYTE_W-1:0] m_byte;
		logic [mbps_pkg::BYTE_W-1:0] k_mask;
		logic                        ok;
		ok = 1'b1;
		for (int k = 0; k < mbps_pkg::MAX_PATTERN; k++) begin
			// position k lines up with the byte len-1-k steps back
			lag    = len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(k);
			m_byte = pattern_match[k*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
			k_mask = pattern_mask[k*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
			if (mbps_pkg::LEN_W'(k) < len) begin
				if ((hist[lag[mbps_pkg::HIST_IW-1:0]] & k_mask) != m_byte) begin
					ok = 1'b0;
				end
			end
		end
		hit = ok;
	end

endmodule

// ===== src/masked_byte_pattern_search_core.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_core
// Result: the request carrying tlast is registered in the input stage, and
// its result is registered in the output register once that byte moves on.
// Throughput: one byte per cycle; a last byte waits while a result is held.
// Reset: arst_n clears the pattern registers to their defaults and the
// region state, the byte window and both pipeline stages at once.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // [7:0] data_byte
	input  logic                            s_axis_tlast,  // last_byte
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [0] found, [20:1] match_offset, [21] region_overflow, [23:22] zero
	output logic [mbps_pkg::RES_DW-1:0]     m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);

	mbps_pkg::cfg_t cfg;

	logic                          valid_s1;
	logic [mbps_pkg::BYTE_W-1:0]   byte_s1;
	logic                          last_s1;

	mbps_pkg::window_t             window_q;
	logic [mbps_pkg::INDEX_W-1:0]  index_q;
	logic                          have_q;
	logic [mbps_pkg::OFFSET_W-1:0] best_q;
	logic                          ovf_q;

	logic                          out_valid_q;
	logic                          out_found_q;
	logic [mbps_pkg::OFFSET_W-1:0] out_offset_q;
	logic                          out_ovf_q;

	logic                          advance;
	logic [mbps_pkg::LEN_W-1:0]    len;
	logic                          hit;
	logic                          in_range;
	logic [mbps_pkg::SUM_W-1:0]    next_pos;
	logic [mbps_pkg::SUM_W-1:0]    len_x;
	logic [mbps_pkg::SUM_W-1:0]    start;
	logic                          take;
	logic                          nxt_have;
	logic [mbps_pkg::OFFSET_W-1:0] nxt_best;
	logic                          nxt_ovf;

	assign cfg_ready = 1'b1;

	mbps_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign len = mbps_pkg::active_len(cfg.pattern_length);

	mbps_match u_match (
		.pattern_match (cfg.pattern_match),
		.pattern_mask  (cfg.pattern_mask),
		.len           (len),
		.cur_byte      (byte_s1),
		.window        (window_q),
		.hit           (hit)
	);

	// a last byte only moves on when the result register can take it
	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_comb begin
		in_range = index_q < mbps_pkg::INDEX_W'(mbps_pkg::MAX_REGION);
		next_pos = mbps_pkg::SUM_W'(index_q) + mbps_pkg::SUM_W'(1);
		len_x    = mbps_pkg::SUM_W'(len);
		start    = next_pos - len_x;
		take     = in_range && (next_pos >= len_x) && hit;
		nxt_have = have_q || take;
		nxt_ovf  = ovf_q || !in_range;
		nxt_best = best_q;
		if (take && (cfg.search_mode == mbps_pkg::MODE_LAST || !have_q)) begin
			nxt_best = start[mbps_pkg::OFFSET_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// region state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			index_q  <= '0;
			have_q   <= 1'b0;
			best_q   <= '0;
			ovf_q    <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				window_q <= '0;
				index_q  <= '0;
				have_q   <= 1'b0;
				best_q   <= '0;
				ovf_q    <= 1'b0;
			end else begin
				if (in_range) begin
					window_q[0] <= byte_s1;
					for (int i = 1; i < mbps_pkg::WIN_D; i++) begin
						window_q[i] <= window_q[i-1];
					end
					index_q <= index_q + mbps_pkg::INDEX_W'(1);
				end
				have_q <= nxt_have;
				best_q <= nxt_best;
				ovf_q  <= nxt_ovf;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_found_q  <= nxt_have;
			out_offset_q <= nxt_best;
			out_ovf_q    <= nxt_ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = mbps_pkg::RES_DW'({out_ovf_q, out_offset_q, out_found_q});

endmodule

// ===== src/mbps_checker.sv =====
// ----------------------------------------------------------------------------
// mbps_checker
// Port-level checks on the search core, bound to the top level.
// ----------------------------------------------------------------------------
module mbps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            s_axis_tlast,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [mbps_pkg::RES_DW-1:0]     m_axis_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	// an empty result register never blocks the input side
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// no match reports offset zero
	a_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[mbps_pkg::OFFSET_W:1] == '0)
		else $error("offset set without a match");

	// a new result needs a last byte taken before it
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready || (s_axis_tvalid && s_axis_tlast), 2)
			|| $past(!s_axis_tready || (s_axis_tvalid && s_axis_tlast), 1))
		else $error("result without a last byte");

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for masked_byte_pattern_search_core. Byte regions go in on the
// input stream, each closed by tlast; a behavioural search model runs on every
// accepted byte and queues the found/offset/overflow result of each region,
// and every result on the output stream is checked against the oldest one.
// Directed cases come first, then random patterns and regions under several
// idling mixes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 7;
	localparam int DRAIN_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int REPORT_LIMIT   = 10;
	localparam int HIST_D         = mbps_pkg::MAX_PATTERN - 1;

	localparam logic [mbps_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
		mbps_pkg::CFG_SEARCH_MODE + 1'b1;
	localparam logic [mbps_pkg::CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

	typedef struct packed {
		logic                          region_overflow;
		logic [mbps_pkg::OFFSET_W-1:0] match_offset;
		logic                          found;
	} search_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [7:0]                      s_axis_tdata;
	logic                            s_axis_tlast;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [mbps_pkg::RES_DW-1:0]     m_axis_tdata;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data;

	masked_byte_pattern_search_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// pattern registers as the block should hold them
	logic [mbps_pkg::WORD_W-1:0]    pat_match_q = '0;
	logic [mbps_pkg::WORD_W-1:0]    pat_mask_q  = '1;
	logic [mbps_pkg::CFG_LEN_W-1:0] pat_len_q   = mbps_pkg::CFG_LEN_W'(1);
	logic                           pat_mode_q  = mbps_pkg::MODE_FIRST;

	// per-region search state
	logic [7:0]                    hist_q [HIST_D];
	int unsigned                   region_bytes;
	bit                            seen_match;
	logic [mbps_pkg::OFFSET_W-1:0] chosen_offset;
	bit                            region_spilled;

	search_result_t pending_results[$];

	bit          byte_taken;
	bit          reg_taken;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned bytes_sent;
	int unsigned fault_count;
	int unsigned quiet_cycles;

	function automatic int unsigned pattern_span();
		if (pat_len_q == '0)
			return 1;
		if (int'(pat_len_q) > mbps_pkg::MAX_PATTERN)
			return mbps_pkg::MAX_PATTERN;
		return int'(pat_len_q);
	endfunction

	function automatic bit position_hit(input int unsigned k, input logic [7:0] b);
		return (b & pat_mask_q[8*k +: 8]) == pat_match_q[8*k +: 8];
	endfunction

	function automatic void clear_region();
		for (int i = 0; i < HIST_D; i++)
			hist_q[i] = '0;
		region_bytes   = 0;
		seen_match     = 1'b0;
		chosen_offset  = '0;
		region_spilled = 1'b0;
	endfunction

	function automatic void apply_register(input logic [mbps_pkg::CFG_IDX_W-1:0] idx,
			input logic [mbps_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			mbps_pkg::CFG_PATTERN_MATCH:  pat_match_q = value;
			mbps_pkg::CFG_PATTERN_MASK:   pat_mask_q  = value;
			mbps_pkg::CFG_PATTERN_LENGTH: pat_len_q   = value[mbps_pkg::CFG_LEN_W-1:0];
			mbps_pkg::CFG_SEARCH_MODE:    pat_mode_q  = value[0];
			default: ;
		endcase
	endfunction

	// advance the search by one byte; return 1 with the region result on tlast
	function automatic bit search_byte(input logic [7:0] b, input bit last,
			output search_result_t res);
		int unsigned n;
		bit ok;
		if (region_bytes < mbps_pkg::MAX_REGION) begin
			n = pattern_span();
			if (region_bytes + 1 >= n) begin
				// hist_q[0] is the byte just before b
				ok = position_hit(n - 1, b);
				for (int k = 0; k + 1 < n; k++) begin
					if (!position_hit(k, hist_q[n - 2 - k]))
						ok = 1'b0;
				end
				if (ok) begin
					if (pat_mode_q == mbps_pkg::MODE_LAST || !seen_match)
						chosen_offset = mbps_pkg::OFFSET_W'(region_bytes + 1 - n);
					seen_match = 1'b1;
				end
			end
			for (int i = HIST_D - 1; i > 0; i--)
				hist_q[i] = hist_q[i - 1];
			hist_q[0] = b;
			region_bytes++;
		end else begin
			region_spilled = 1'b1;
		end
		res = '0;
		if (!last)
			return 1'b0;
		res.found           = seen_match;
		res.match_offset    = seen_match ? chosen_offset : '0;
		res.region_overflow = region_spilled;
		clear_region();
		return 1'b1;
	endfunction

	function automatic void flag_fault(input string what, input longint unsigned want,
			input longint unsigned got);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("mismatch on %0s: expected 0x%0h, got 0x%0h at %0t", what, want, got,
				$time);
	endfunction

	// track requests on both input channels
	always @(posedge clk or negedge arst_n) begin : track_requests
		search_result_t res;
		if (!arst_n) begin
			pat_match_q = '0;
			pat_mask_q  = '1;
			pat_len_q   = mbps_pkg::CFG_LEN_W'(1);
			pat_mode_q  = mbps_pkg::MODE_FIRST;
			clear_region();
			byte_taken <= 1'b0;
			reg_taken  <= 1'b0;
		end else begin
			byte_taken <= s_axis_tvalid && s_axis_tready;
			reg_taken  <= cfg_valid && cfg_ready;
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				if (search_byte(s_axis_tdata, s_axis_tlast, res))
					pending_results.push_back(res);
			end
		end
	end

	always @(posedge clk) begin : check_results
		search_result_t want;
		search_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[mbps_pkg::RES_W-1:0];
			if (pending_results.size() == 0) begin
				flag_fault("result with none pending", 0, m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got.found !== want.found)
					flag_fault("found", want.found, got.found);
				if (got.match_offset !== want.match_offset)
					flag_fault("match_offset", want.match_offset, got.match_offset);
				if (got.region_overflow !== want.region_overflow)
					flag_fault("region_overflow", want.region_overflow, got.region_overflow);
				if (m_axis_tdata[mbps_pkg::RES_DW-1:mbps_pkg::RES_W] !== '0)
					flag_fault("tdata padding", 0,
						m_axis_tdata[mbps_pkg::RES_DW-1:mbps_pkg::RES_W]);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("masked_byte_pattern_search_core regression: fail");
				$finish;
			end
		end
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	task automatic send_byte(input logic [7:0] b, input bit last);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(negedge clk); while (!byte_taken);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [mbps_pkg::CFG_IDX_W-1:0] idx,
			input logic [mbps_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(negedge clk); while (!reg_taken);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, let every pending result out, then let the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// random bytes with the pattern planted a few times
	task automatic send_region(input int unsigned n_bytes, input int unsigned plants);
		logic [7:0] region_q[$];
		int unsigned span;
		int unsigned start;
		span = pattern_span();
		for (int i = 0; i < n_bytes; i++)
			region_q.push_back(8'($urandom));
		if (n_bytes >= span) begin
			repeat (plants) begin
				start = $urandom_range(n_bytes - span);
				for (int k = 0; k < span; k++)
					region_q[start + k] = (8'($urandom) & ~pat_mask_q[8*k +: 8]) |
						pat_match_q[8*k +: 8];
			end
		end
		for (int i = 0; i < n_bytes; i++)
			send_byte(region_q[i], i == n_bytes - 1);
	endtask

	task automatic pick_random_pattern();
		logic [mbps_pkg::WORD_W-1:0]     mask;
		logic [mbps_pkg::WORD_W-1:0]     match;
		logic [mbps_pkg::CFG_DATA_W-1:0] len_word;
		case ($urandom_range(3))
			0:       mask = '1;
			1:       mask = '0;
			default: mask = {$urandom, $urandom};
		endcase
		case ($urandom_range(7))
			0:       match = '0;
			1:       match = '1;
			2:       match = {$urandom, $urandom};
			default: match = {$urandom, $urandom} & mask;
		endcase
		len_word = {$urandom, $urandom};
		len_word[mbps_pkg::CFG_LEN_W-1:0] = ($urandom_range(3) == 0) ?
			mbps_pkg::CFG_LEN_W'($urandom_range(15)) :
			mbps_pkg::CFG_LEN_W'($urandom_range(1, mbps_pkg::MAX_PATTERN));
		write_reg(mbps_pkg::CFG_PATTERN_MATCH, match);
		write_reg(mbps_pkg::CFG_PATTERN_MASK, mask);
		write_reg(mbps_pkg::CFG_PATTERN_LENGTH, len_word);
		write_reg(mbps_pkg::CFG_SEARCH_MODE, {$urandom, $urandom});
		if ($urandom_range(3) == 0)
			write_reg(mbps_pkg::CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
				{$urandom, $urandom});
	endtask

	task automatic test_reset_defaults();
		// single zero byte with full mask after reset
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h37, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_idle();
	endtask

	task automatic test_length_clamp();
		// length zero acts as one
		write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
		write_reg(mbps_pkg::CFG_PATTERN_MATCH, 64'h0000_0000_0000_00A5);
		send_byte(8'h11, 1'b0);
		send_byte(8'hA5, 1'b1);
		wait_idle();
		// length fifteen acts as the full pattern
		write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'h0000_0000_0000_00FF);
		write_reg(mbps_pkg::CFG_PATTERN_MATCH, 64'h8877_6655_4433_2211);
		for (int i = 0; i < mbps_pkg::MAX_PATTERN; i++)
			send_byte(pat_match_q[8*i +: 8], i == mbps_pkg::MAX_PATTERN - 1);
		wait_idle();
	endtask

	task automatic test_search_modes();
		logic [7:0] twin [6] = '{8'h01, 8'h02, 8'hF3, 8'h01, 8'h02, 8'h03};
		logic [7:0] lone [4] = '{8'h01, 8'h02, 8'h13, 8'h01};
		write_reg(mbps_pkg::CFG_PATTERN_MATCH, 64'h0000_0000_0003_0201);
		write_reg(mbps_pkg::CFG_PATTERN_MASK, 64'hFFFF_FFFF_FF0F_FFFF);
		write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'd3);
		write_reg(mbps_pkg::CFG_SEARCH_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
		foreach (twin[i])
			send_byte(twin[i], i == 5);
		wait_idle();
		write_reg(mbps_pkg::CFG_SEARCH_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
		foreach (lone[i])
			send_byte(lone[i], i == 3);
		// region shorter than the pattern
		send_byte(8'h01, 1'b0);
		send_byte(8'h02, 1'b1);
		wait_idle();
	endtask

	task automatic test_impossible_byte();
		// match byte with a bit outside its mask never hits
		write_reg(mbps_pkg::CFG_PATTERN_LENGTH, 64'd1);
		write_reg(mbps_pkg::CFG_PATTERN_MATCH, 64'h0000_0000_0000_0081);
		write_reg(mbps_pkg::CFG_PATTERN_MASK, 64'h0000_0000_0000_000F);
		send_byte(8'h81, 1'b1);
		wait_idle();
		// writes beyond the register list leave the pattern alone
		write_reg(CFG_FIRST_UNUSED, {$urandom, $urandom});
		write_reg(CFG_LAST_UNUSED, {$urandom, $urandom});
		send_byte(8'h81, 1'b1);
		wait_idle();
	endtask

	task automatic test_random_traffic(input int unsigned idle_in, input int unsigned stall_out,
			input int unsigned budget);
		int unsigned stop_at;
		int unsigned n_bytes;
		gap_pct   = idle_in;
		stall_pct = stall_out;
		stop_at   = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			pick_random_pattern();
			repeat (4) begin
				case ($urandom_range(19))
					0:             n_bytes = $urandom_range(65, 300);
					1, 2, 3, 4:    n_bytes = $urandom_range(17, 64);
					default:       n_bytes = $urandom_range(1, 16);
				endcase
				send_region(n_bytes, ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 3));
			end
			wait_idle();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b1;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		gap_pct       = 0;
		stall_pct     = 0;
		bytes_sent    = 0;
		fault_count   = 0;
		quiet_cycles  = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_length_clamp();
		test_search_modes();
		test_impossible_byte();
		test_random_traffic(0, 0, 475);
		test_random_traffic(67, 0, 475);
		test_random_traffic(0, 67, 475);
		test_random_traffic(29, 29, 475);

		wait_idle();
		if (pending_results.size() != 0)
			flag_fault("results never delivered", pending_results.size(), 0);
		if (fault_count == 0)
			$display("masked_byte_pattern_search_core regression: pass");
		else
			$display("masked_byte_pattern_search_core regression: fail");
		$finish;
	end

endmodule
